/* rtl/apq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apq_pkg
// Types and codes shared by the aging priority queue cells and top level.
// ----------------------------------------------------------------------------
package apq_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 3;

    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t               operation;
        logic [ID_W-1:0]   requester_id;
        logic [PRIO_W-1:0] priority_req;
    } in_item_t;

    typedef struct packed
    {
        logic               served_valid;
        logic [ID_W-1:0]    served_id;
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    // contents of one queue slot
    typedef struct packed
    {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    // operation broadcast to every cell
    typedef struct packed
    {
        logic              enq;
        logic              deq;
        logic [ID_W-1:0]   new_id;
        logic [PRIO_W-1:0] new_prio;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/apq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted queue: inserts, shifts toward the tail on enqueue,
// shifts toward the head with aging on dequeue.
// ----------------------------------------------------------------------------
module apq_cell
    import apq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire slot_t      prev_slot,
    input  wire logic       prev_after,
    input  wire slot_t      next_slot,
    output slot_t           slot,
    output logic            after
);

    slot_t slot_reg;
    slot_t slot_next;

    // new item belongs in front of this slot (monotone along the chain)
    assign after = !(slot_reg.valid && (slot_reg.prio >= ctrl.new_prio));
    assign slot  = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.deq)
        begin
            slot_next.valid = next_slot.valid;
            slot_next.id    = next_slot.id;
            slot_next.prio  = (next_slot.prio == PRIO_MAX) ? PRIO_MAX
                                                           : next_slot.prio + 1'b1;
        end
        else if (ctrl.enq && after)
        begin
            if (prev_after)
            begin
                slot_next = prev_slot;
            end
            else
            begin
                slot_next.valid = 1'b1;
                slot_next.id    = ctrl.new_id;
                slot_next.prio  = ctrl.new_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/aging_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aging_priority_queue_core
// Sorted priority queue with aging, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the item is accepted
// throughput: one item per cycle; each cell updates from its two neighbors
//   combinationally, so the next item is taken whenever the result register
//   is empty or being drained
// reset: all slots invalid, count zero, no result pending
module aging_priority_queue_core
    import apq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_item_reg;
    out_item_t        out_item_next;

    cell_ctrl_t       ctrl;
    slot_t            slots [QUEUE_DEPTH];
    logic             after [QUEUE_DEPTH];
    logic             accept;
    logic             is_full;
    logic             is_empty;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg == DEPTH_CNT);
    assign is_empty  = (count_reg == '0);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        ctrl.enq      = accept && (in_item.operation == OP_ENQUEUE) && !is_full;
        ctrl.deq      = accept && (in_item.operation == OP_DEQUEUE) && !is_empty;
        ctrl.new_id   = in_item.requester_id;
        ctrl.new_prio = in_item.priority_req;
    end

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            slot_t prev_slot;
            slot_t next_slot;
            logic  prev_after;

            if (k == 0)
            begin : g_head
                assign prev_slot  = '0;
                assign prev_after = 1'b0;
            end
            else
            begin : g_mid
                assign prev_slot  = slots[k-1];
                assign prev_after = after[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_slot = '0;
            end
            else
            begin : g_body
                assign next_slot = slots[k+1];
            end

            apq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_slot  (prev_slot),
                .prev_after (prev_after),
                .next_slot  (next_slot),
                .slot       (slots[k]),
                .after      (after[k])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (accept)
        begin
            out_valid_next             = 1'b1;
            out_item_next.served_valid = ctrl.deq;
            out_item_next.served_id    = ctrl.deq ? slots[0].id : '0;
            out_item_next.entry_count  = COUNT_W'(count_next);
            if (in_item.operation == OP_DEQUEUE)
            begin
                out_item_next.status = is_empty ? STATUS_EMPTY : STATUS_OK;
            end
            else
            begin
                out_item_next.status = is_full ? STATUS_FULL : STATUS_OK;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule
`default_nettype wire
